/* src/ddim_pkg.sv */
`timescale 1ns / 1ps

package ddim_pkg;

    localparam int KeyNum      = 3;
    localparam int CountW      = 4;
    localparam int PeakW       = 10;
    localparam int StepW       = 8;
    localparam int DutyW       = 16;
    localparam int CfgIdxW     = 3;
    localparam int CfgDataW    = 10;

    localparam logic [CountW-1:0] COUNT_MAX = 4'hF;

    // mode codes
    localparam logic [1:0] MODE_TEST   = 2'd0;
    localparam logic [1:0] MODE_FADE   = 2'd1;
    localparam logic [1:0] MODE_MANUAL = 2'd2;

    // key event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_MODE   = 2'd1;
    localparam logic [1:0] EV_FIRST  = 2'd2;
    localparam logic [1:0] EV_SECOND = 2'd3;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_PRESS_LEVEL   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_RELEASE_LEVEL = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_FADE_PEAK     = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_SECOND_START  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_MANUAL_STEP   = 3'd4;

    typedef struct packed {
        logic [CountW-1:0] press_level;
        logic [CountW-1:0] release_level;
    } key_cfg_t;

    typedef struct packed {
        logic en;
        logic start;
    } key_ctl_t;

    typedef struct packed {
        logic [DutyW-1:0] level;
        logic             falling;
    } ramp_t;

    typedef struct packed {
        logic [DutyW-1:0] first_duty;
        logic [DutyW-1:0] second_duty;
        logic [1:0]       mode_now;
        logic [1:0]       key_event;
    } result_t;

    // one triangle step; wraps modulo 2^16 off the ramp
    function automatic ramp_t ramp_step(input logic [DutyW-1:0] lvl,
                                        input logic falling,
                                        input logic [PeakW-1:0] peak);
        ramp_t r;
        r.level   = lvl;
        r.falling = falling;
        if (!falling) begin
            r.level = lvl + 16'd1;
            if (r.level == {{(DutyW-PeakW){1'b0}}, peak}) begin
                r.falling = 1'b1;
            end
        end else begin
            r.level = lvl - 16'd1;
            if (r.level == '0) begin
                r.falling = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

/* src/dual_led_dimmer_with_key_debounce_unit.sv */
`timescale 1ns / 1ps
// A word accepted on the s_ side is registered into the head, or into the skid while the head is held.
// Throughput: one word per cycle while s_ready is high; three key lanes debounce in parallel and merge combinationally.
// A two-word output buffer keeps s_ready high while one finished word waits.
// Reset (aresetn low, synchronous): fade mode, duties 0 and 511, debounce state
// cleared, output buffer empty, registers back to their defaults.
module dual_led_dimmer_with_key_debounce_unit
    import ddim_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic                s_mode_key,
    input  logic                s_first_key,
    input  logic                s_second_key,
    input  logic                s_shutdown,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [DutyW-1:0]    m_first_duty,
    output logic [DutyW-1:0]    m_second_duty,
    output logic [1:0]          m_mode_now,
    output logic [1:0]          m_key_event
);

    logic [CountW-1:0] press_level_reg, release_level_reg;
    logic [PeakW-1:0]  fade_peak_reg, second_start_reg;
    logic [StepW-1:0]  manual_step_reg;

    logic [1:0]       mode_reg, mode_next;
    logic [DutyW-1:0] first_level_reg, first_level_next;
    logic [DutyW-1:0] second_level_reg, second_level_next;
    logic             first_falling_reg, first_falling_next;
    logic             second_falling_reg, second_falling_next;

    result_t head_reg, head_next;
    result_t skid_reg, skid_next;
    logic    head_valid_reg, head_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    logic          push, pop;
    key_ctl_t      lane_ctl;
    key_cfg_t      lane_cfg;
    logic [KeyNum-1:0] keys, events;
    logic [1:0]    ev;
    ramp_t         first_ramp, second_ramp;
    logic [DutyW-1:0] fade_first, fade_second;
    logic          fade_first_fall, fade_second_fall;
    result_t       new_word;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_level_reg   <= 4'd12;
            release_level_reg <= 4'd4;
            fade_peak_reg     <= 10'd1023;
            second_start_reg  <= 10'd511;
            manual_step_reg   <= 8'd16;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PRESS_LEVEL:   press_level_reg   <= cfg_wdata[CountW-1:0];
                CFG_RELEASE_LEVEL: release_level_reg <= cfg_wdata[CountW-1:0];
                CFG_FADE_PEAK:     fade_peak_reg     <= cfg_wdata[PeakW-1:0];
                CFG_SECOND_START:  second_start_reg  <= cfg_wdata[PeakW-1:0];
                CFG_MANUAL_STEP:   manual_step_reg   <= cfg_wdata[StepW-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready = !skid_valid_reg;
    assign push    = s_valid && s_ready;
    assign pop     = head_valid_reg && m_ready;

    assign lane_ctl.en            = push;
    assign lane_ctl.start         = s_kind;
    assign lane_cfg.press_level   = press_level_reg;
    assign lane_cfg.release_level = release_level_reg;
    assign keys = {s_second_key, s_first_key, s_mode_key};

    genvar k;
    generate
        for (k = 0; k < KeyNum; k++) begin : g_lane
            ddim_key_lane u_lane (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (lane_ctl),
                .cfg        (lane_cfg),
                .pressed    (keys[k]),
                .press_event(events[k])
            );
        end
    endgenerate

    // merge: highest-numbered key wins
    always_comb begin
        ev = EV_NONE;
        if (events[2]) begin
            ev = EV_SECOND;
        end else if (events[1]) begin
            ev = EV_FIRST;
        end else if (events[0]) begin
            ev = EV_MODE;
        end
    end

    // fade ramp; a mode press restarts both channels from zero before the step
    always_comb begin
        fade_first       = first_level_reg;
        fade_second      = second_level_reg;
        fade_first_fall  = first_falling_reg;
        fade_second_fall = second_falling_reg;
        if (ev == EV_MODE) begin
            fade_first       = '0;
            fade_second      = '0;
            fade_first_fall  = 1'b0;
            fade_second_fall = 1'b0;
        end
        first_ramp  = ramp_step(fade_first, fade_first_fall, fade_peak_reg);
        second_ramp = ramp_step(fade_second, fade_second_fall, fade_peak_reg);
    end

    always_comb begin
        mode_next           = mode_reg;
        first_level_next    = first_level_reg;
        second_level_next   = second_level_reg;
        first_falling_next  = first_falling_reg;
        second_falling_next = second_falling_reg;
        if (s_kind) begin
            if (s_mode_key) begin
                mode_next         = MODE_TEST;
                first_level_next  = {{(DutyW-PeakW){1'b0}}, fade_peak_reg};
                second_level_next = {{(DutyW-PeakW){1'b0}}, fade_peak_reg};
            end else begin
                mode_next           = MODE_FADE;
                first_level_next    = '0;
                second_level_next   = {{(DutyW-PeakW){1'b0}}, second_start_reg};
                first_falling_next  = 1'b0;
                second_falling_next = 1'b0;
            end
        end else begin
            case (mode_reg)
                MODE_TEST: ;
                MODE_FADE: begin
                    if (ev == EV_MODE) begin
                        mode_next = MODE_MANUAL;
                    end
                    first_level_next    = first_ramp.level;
                    first_falling_next  = first_ramp.falling;
                    second_level_next   = second_ramp.level;
                    second_falling_next = second_ramp.falling;
                end
                MODE_MANUAL: begin
                    if (ev == EV_FIRST) begin
                        first_level_next = first_level_reg
                                         + {{(DutyW-StepW){1'b0}}, manual_step_reg};
                    end
                    if (ev == EV_SECOND) begin
                        second_level_next = second_level_reg
                                          + {{(DutyW-StepW){1'b0}}, manual_step_reg};
                    end
                    if (ev == EV_MODE) begin
                        mode_next           = MODE_FADE;
                        first_level_next    = '0;
                        second_level_next   = {{(DutyW-PeakW){1'b0}}, second_start_reg};
                        first_falling_next  = 1'b0;
                        second_falling_next = 1'b0;
                    end
                end
                default: begin
                    mode_next           = MODE_FADE;
                    first_level_next    = '0;
                    second_level_next   = {{(DutyW-PeakW){1'b0}}, second_start_reg};
                    first_falling_next  = 1'b0;
                    second_falling_next = 1'b0;
                end
            endcase
            if (s_shutdown) begin
                first_level_next  = '0;
                second_level_next = '0;
            end
        end
    end

    always_comb begin
        new_word.first_duty  = first_level_next;
        new_word.second_duty = second_level_next;
        new_word.mode_now    = mode_next;
        new_word.key_event   = s_kind ? EV_NONE : ev;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg           <= MODE_FADE;
            first_level_reg    <= '0;
            second_level_reg   <= 16'd511;
            first_falling_reg  <= 1'b0;
            second_falling_reg <= 1'b0;
        end else if (push) begin
            mode_reg           <= mode_next;
            first_level_reg    <= first_level_next;
            second_level_reg   <= second_level_next;
            first_falling_reg  <= first_falling_next;
            second_falling_reg <= second_falling_next;
        end
    end

    // two-word output buffer: head drives the m_ side, skid holds one more
    always_comb begin
        head_next       = head_reg;
        skid_next       = skid_reg;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (head_valid_reg && !pop) begin
            if (push) begin
                skid_next       = new_word;
                skid_valid_next = 1'b1;
            end
        end else if (skid_valid_reg) begin
            head_next       = skid_reg;
            head_valid_next = 1'b1;
            skid_valid_next = 1'b0;
        end else begin
            head_next       = new_word;
            head_valid_next = push;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign m_valid       = head_valid_reg;
    assign m_first_duty  = head_reg.first_duty;
    assign m_second_duty = head_reg.second_duty;
    assign m_mode_now    = head_reg.mode_now;
    assign m_key_event   = head_reg.key_event;

endmodule

/* src/ddim_key_lane.sv */
`timescale 1ns / 1ps

module ddim_key_lane
    import ddim_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  key_ctl_t ctl,
    input  key_cfg_t cfg,
    input  logic     pressed,
    output logic     press_event
);

    logic [CountW-1:0] count_reg, count_next;
    logic              level_reg, level_next;
    logic              seen_reg, seen_next;
    logic [CountW-1:0] count_step;
    logic              level_step;

    always_comb begin
        count_next  = count_reg;
        level_next  = level_reg;
        seen_next   = seen_reg;
        press_event = 1'b0;
        count_step  = count_reg;
        level_step  = level_reg;
        if (pressed && count_reg != COUNT_MAX) begin
            count_step = count_reg + 4'd1;
            level_step = (count_step == cfg.press_level) ? 1'b1 : level_reg;
            count_next = count_step;
            level_next = level_step;
            if (level_step && !seen_reg) begin
                press_event = 1'b1;
                seen_next   = 1'b1;
            end
        end else if (!pressed && count_reg != '0) begin
            count_step = count_reg - 4'd1;
            level_step = (count_step == cfg.release_level) ? 1'b0 : level_reg;
            count_next = count_step;
            level_next = level_step;
            if (!level_step && seen_reg) begin
                seen_next = 1'b0;
            end
        end
        if (ctl.start) begin
            count_next  = '0;
            level_next  = 1'b0;
            seen_next   = 1'b0;
            press_event = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            level_reg <= 1'b0;
            seen_reg  <= 1'b0;
        end else if (ctl.en) begin
            count_reg <= count_next;
            level_reg <= level_next;
            seen_reg  <= seen_next;
        end
    end

endmodule
